@@ design/rwia_pkg.sv @@
// Package for the rotated wide integer ALU: sizes, command and state codes,
// and the control structs passed between the submodules. No dependencies.
`default_nettype none

package rwia_pkg;

   localparam int DigitCount = 35;
   localparam int DigitBits  = 7;
   localparam int ByteBits   = 8;
   localparam int TotalBits  = DigitCount * DigitBits;
   localparam int SlotBits   = $clog2(DigitCount + 1);
   localparam int RotBits    = $clog2(TotalBits);
   localparam int CntBits    = $clog2(TotalBits + 1);

   typedef logic [TotalBits-1:0] word_type;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_EQ   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GATHER,
      ST_ROTATE,
      ST_EXEC,
      ST_EMIT,
      ST_FLAG
   } state_type;

   typedef struct packed {
      logic clear;
      logic gather;
      logic rotate;
   } unpack_ctl_type;

   typedef struct packed {
      logic    start;
      cmd_type op;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

`default_nettype wire

@@ design/rwia_opstore.sv @@
// Operand byte stores for both operands, one write and one registered read a cycle.
// Depends on rwia_pkg.
`default_nettype none

module rwia_opstore (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [rwia_pkg::SlotBits-1:0] wr_addr,
   input  wire logic [rwia_pkg::ByteBits-1:0] wr_lhs,
   input  wire logic [rwia_pkg::ByteBits-1:0] wr_rhs,
   input  wire logic [rwia_pkg::SlotBits-1:0] rd_addr,
   output logic      [rwia_pkg::ByteBits-1:0] rd_lhs_ff,
   output logic      [rwia_pkg::ByteBits-1:0] rd_rhs_ff
);

   logic [rwia_pkg::ByteBits-1:0] lhs_mem_ff [rwia_pkg::DigitCount];
   logic [rwia_pkg::ByteBits-1:0] rhs_mem_ff [rwia_pkg::DigitCount];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lhs_mem_ff[wr_addr] <= wr_lhs;
         rhs_mem_ff[wr_addr] <= wr_rhs;
      end
   end

   always_ff @(posedge clock) begin
      rd_lhs_ff <= lhs_mem_ff[rd_addr];
      rd_rhs_ff <= rhs_mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/rwia_unpack.sv @@
// Operand decoder: gathers stored bytes into value registers, folds the rotation
// count modulo the word width and rotates right one bit a cycle. Depends on rwia_pkg.
`default_nettype none

module rwia_unpack (
   input  wire logic                          clock,
   input  wire rwia_pkg::unpack_ctl_type      ctl,
   input  wire logic [rwia_pkg::ByteBits-1:0] lhs_byte,
   input  wire logic [rwia_pkg::ByteBits-1:0] rhs_byte,
   output rwia_pkg::word_type                 a_val,
   output rwia_pkg::word_type                 b_val,
   output logic                               rot_done
);

   localparam int Db = rwia_pkg::DigitBits;
   localparam int Tb = rwia_pkg::TotalBits;
   localparam int Rb = rwia_pkg::RotBits;

   rwia_pkg::word_type a_ff, a_in, b_ff, b_in;
   logic [Rb-1:0]      rot_a_ff, rot_a_in, rot_b_ff, rot_b_in;

   // The count arrives most significant bit first, so each step doubles and reduces.
   function automatic logic [Rb-1:0] rot_step(input logic [Rb-1:0] rot, input logic bit_in);
      logic [Rb:0] t;
      t = {rot, bit_in};
      if (t >= (Rb+1)'(Tb)) begin
         t = t - (Rb+1)'(Tb);
      end
      return t[Rb-1:0];
   endfunction

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      rot_a_in = rot_a_ff;
      rot_b_in = rot_b_ff;
      if (ctl.clear) begin
         rot_a_in = '0;
         rot_b_in = '0;
      end else if (ctl.gather) begin
         // Slot zero holds the top digit, so bytes enter at the bottom and move up.
         a_in     = {a_ff[Tb-Db-1:0], lhs_byte[Db-1:0]};
         b_in     = {b_ff[Tb-Db-1:0], rhs_byte[Db-1:0]};
         rot_a_in = rot_step(rot_a_ff, lhs_byte[Db]);
         rot_b_in = rot_step(rot_b_ff, rhs_byte[Db]);
      end else if (ctl.rotate) begin
         if (rot_a_ff != '0) begin
            a_in     = {a_ff[0], a_ff[Tb-1:1]};
            rot_a_in = rot_a_ff - Rb'(1);
         end
         if (rot_b_ff != '0) begin
            b_in     = {b_ff[0], b_ff[Tb-1:1]};
            rot_b_in = rot_b_ff - Rb'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      rot_a_ff <= rot_a_in;
      rot_b_ff <= rot_b_in;
   end

   assign a_val    = a_ff;
   assign b_val    = b_ff;
   assign rot_done = (rot_a_ff == '0) && (rot_b_ff == '0);

endmodule

`default_nettype wire

@@ design/rwia_alu.sv @@
// Iterative wide ALU: add and subtract in one step, shift-add multiply and
// restoring division one bit per cycle. Depends on rwia_pkg.
`default_nettype none

module rwia_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rwia_pkg::alu_req_type req,
   input  wire rwia_pkg::word_type    a_val,
   input  wire rwia_pkg::word_type    b_val,
   output rwia_pkg::word_type         result,
   output rwia_pkg::alu_sts_type      sts
);

   localparam int Tb = rwia_pkg::TotalBits;
   localparam int Cb = rwia_pkg::CntBits;

   logic               busy_ff, busy_in, done_ff, done_in;
   rwia_pkg::cmd_type  op_ff, op_in;
   logic [Cb-1:0]      cnt_ff, cnt_in;
   rwia_pkg::word_type x_ff, x_in, y_ff, y_in, acc_ff, acc_in;
   logic [Tb:0]        div_diff;
   logic               div_take;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      div_diff = {1'b0, acc_ff[Tb-2:0], x_ff[Tb-1]} - {1'b0, y_ff};
      // A set top bit means the shifted remainder already exceeds the divisor.
      div_take = acc_ff[Tb-1] | ~div_diff[Tb];
      if (req.start) begin
         op_in  = req.op;
         x_in   = a_val;
         y_in   = b_val;
         cnt_in = Cb'(Tb);
         unique case (req.op)
            rwia_pkg::CMD_ADD: begin
               acc_in  = a_val + b_val;
               done_in = 1'b1;
            end
            rwia_pkg::CMD_SUB: begin
               acc_in  = a_val - b_val;
               done_in = 1'b1;
            end
            rwia_pkg::CMD_MUL, rwia_pkg::CMD_DIV: begin
               acc_in  = '0;
               busy_in = 1'b1;
            end
            default: begin
               acc_in  = '0;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == rwia_pkg::CMD_MUL) begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[Tb-2:0], 1'b0};
            y_in = {1'b0, y_ff[Tb-1:1]};
         end else begin
            acc_in = div_take ? div_diff[Tb-1:0] : {acc_ff[Tb-2:0], x_ff[Tb-1]};
            x_in   = {x_ff[Tb-2:0], div_take};
         end
         cnt_in = cnt_ff - Cb'(1);
         if (cnt_ff == Cb'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign result   = (op_ff == rwia_pkg::CMD_DIV) ? x_ff : acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

`default_nettype wire

@@ design/rotated_wide_int_alu_top.sv @@
// Rotated wide integer ALU. A load transfer writes one in-range byte slot of both stores.
// An operation gathers both operands and rotates them right one bit a step; add and
// subtract then take one ALU step, multiply and divide iterate bit by bit, and the result
// goes out one digit per transfer. A compare, or a divide by zero, skips the ALU and sends
// a single flag item. Requests stall until the last result is registered. Reset is
// synchronous and clears control state; the operand stores hold nothing until loaded.
`default_nettype none

module rotated_wide_int_alu_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_cmd,
   input  wire logic [5:0] req_byte_slot,
   input  wire logic [7:0] req_lhs_byte,
   input  wire logic [7:0] req_rhs_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_result_byte,
   output logic [5:0]      rsp_out_slot,
   output logic            rsp_last,
   output logic            rsp_status,
   output logic            rsp_equal_flag
);

   localparam int Db = rwia_pkg::DigitBits;
   localparam int Tb = rwia_pkg::TotalBits;
   localparam int Sb = rwia_pkg::SlotBits;

   rwia_pkg::state_type      state_ff, state_in;
   rwia_pkg::cmd_type        op_ff, op_in;
   logic [Sb-1:0]            cnt_ff, cnt_in;
   rwia_pkg::word_type       res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [Db-1:0]            rsp_byte_ff, rsp_byte_in;
   logic [Sb-1:0]            rsp_slot_ff, rsp_slot_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic                     rsp_eq_ff, rsp_eq_in;
   logic                     flag_status_ff, flag_status_in, flag_eq_ff, flag_eq_in;

   logic                     accept, wr_en, out_free;
   logic [Sb-1:0]            rd_addr;
   logic [7:0]               rd_lhs, rd_rhs;
   rwia_pkg::unpack_ctl_type unpack_ctl;
   rwia_pkg::word_type       a_val, b_val, alu_result;
   logic                     rot_done;
   rwia_pkg::alu_req_type    alu_req;
   rwia_pkg::alu_sts_type    alu_sts;

   assign req_stall = (state_ff != rwia_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_cmd == rwia_pkg::CMD_LOAD)
                      && (req_byte_slot < Sb'(rwia_pkg::DigitCount));
   assign rd_addr   = (cnt_ff < Sb'(rwia_pkg::DigitCount)) ? cnt_ff : '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   rwia_opstore u_opstore (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_byte_slot),
      .wr_lhs    (req_lhs_byte),
      .wr_rhs    (req_rhs_byte),
      .rd_addr   (rd_addr),
      .rd_lhs_ff (rd_lhs),
      .rd_rhs_ff (rd_rhs)
   );

   rwia_unpack u_unpack (
      .clock    (clock),
      .ctl      (unpack_ctl),
      .lhs_byte (rd_lhs),
      .rhs_byte (rd_rhs),
      .a_val    (a_val),
      .b_val    (b_val),
      .rot_done (rot_done)
   );

   rwia_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a_val  (a_val),
      .b_val  (b_val),
      .result (alu_result),
      .sts    (alu_sts)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cnt_in         = cnt_ff;
      res_in         = res_ff;
      flag_status_in = flag_status_ff;
      flag_eq_in     = flag_eq_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_eq_in      = rsp_eq_ff;
      unpack_ctl     = '0;
      alu_req.start  = 1'b0;
      alu_req.op     = op_ff;
      unique case (state_ff)
         rwia_pkg::ST_IDLE: begin
            if (accept && (req_cmd >= rwia_pkg::CMD_ADD) && (req_cmd <= rwia_pkg::CMD_EQ)) begin
               op_in            = rwia_pkg::cmd_type'(req_cmd);
               cnt_in           = '0;
               unpack_ctl.clear = 1'b1;
               state_in         = rwia_pkg::ST_GATHER;
            end
         end
         rwia_pkg::ST_GATHER: begin
            // Read data arrives in the cycle after its address.
            unpack_ctl.gather = (cnt_ff != '0);
            cnt_in            = cnt_ff + Sb'(1);
            if (cnt_ff == Sb'(rwia_pkg::DigitCount)) begin
               state_in = rwia_pkg::ST_ROTATE;
            end
         end
         rwia_pkg::ST_ROTATE: begin
            unpack_ctl.rotate = 1'b1;
            if (rot_done) begin
               if (op_ff == rwia_pkg::CMD_EQ) begin
                  flag_status_in = 1'b0;
                  flag_eq_in     = (a_val == b_val);
                  state_in       = rwia_pkg::ST_FLAG;
               end else if ((op_ff == rwia_pkg::CMD_DIV) && (b_val == '0)) begin
                  flag_status_in = 1'b1;
                  flag_eq_in     = 1'b0;
                  state_in       = rwia_pkg::ST_FLAG;
               end else begin
                  alu_req.start = 1'b1;
                  state_in      = rwia_pkg::ST_EXEC;
               end
            end
         end
         rwia_pkg::ST_EXEC: begin
            if (alu_sts.done) begin
               res_in   = alu_result;
               cnt_in   = '0;
               state_in = rwia_pkg::ST_EMIT;
            end
         end
         rwia_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = res_ff[Tb-1:Tb-Db];
               rsp_slot_in   = cnt_ff;
               rsp_last_in   = (cnt_ff == Sb'(rwia_pkg::DigitCount - 1));
               rsp_status_in = 1'b0;
               rsp_eq_in     = 1'b0;
               res_in        = {res_ff[Tb-Db-1:0], Db'(0)};
               cnt_in        = cnt_ff + Sb'(1);
               if (cnt_ff == Sb'(rwia_pkg::DigitCount - 1)) begin
                  state_in = rwia_pkg::ST_IDLE;
               end
            end
         end
         rwia_pkg::ST_FLAG: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_slot_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = flag_status_ff;
               rsp_eq_in     = flag_eq_ff;
               state_in      = rwia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rwia_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rwia_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      cnt_ff         <= cnt_in;
      res_ff         <= res_in;
      flag_status_ff <= flag_status_in;
      flag_eq_ff     <= flag_eq_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_eq_ff      <= rsp_eq_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_out_slot    = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_equal_flag  = rsp_eq_ff;

   // An operation transfer must hold off further requests on the next cycle.
   a_op_stalls: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd >= rwia_pkg::CMD_ADD) && (req_cmd <= rwia_pkg::CMD_EQ))
      |=> req_stall)
      else $error("operation accepted but request side not stalled");

   // Error and flag results are always a single item at slot zero.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status || rsp_equal_flag)) |-> (rsp_last && (rsp_out_slot == '0)))
      else $error("flag result is not a single final item");

   // The ALU finishes only while the controller waits for it.
   a_alu_done_exec: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> (state_ff == rwia_pkg::ST_EXEC))
      else $error("ALU finished outside the execute state");

   // The ALU never starts while still iterating.
   a_alu_no_restart: assert property (@(posedge clock) disable iff (reset)
      alu_sts.busy |-> !alu_req.start)
      else $error("ALU started while busy");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for rotated_wide_int_alu_top: loads rotated operands,
// runs every operation and predicts the result bytes. Depends on rwia_pkg.
`default_nettype none

module tb_top;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int RandItems = 290;
   localparam int Dc = rwia_pkg::DigitCount;
   localparam int Db = rwia_pkg::DigitBits;
   localparam int Tb = rwia_pkg::TotalBits;

   typedef struct packed {
      logic [2:0] cmd;
      logic [5:0] slot;
      logic [7:0] lhs;
      logic [7:0] rhs;
   } alu_item_type;

   typedef struct packed {
      logic [6:0] result_byte;
      logic [5:0] out_slot;
      logic       last;
      logic       status;
      logic       equal_flag;
   } result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_cmd = '0;
   logic [5:0] req_byte_slot = '0;
   logic [7:0] req_lhs_byte = '0;
   logic [7:0] req_rhs_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic [6:0] rsp_result_byte;
   logic [5:0] rsp_out_slot;
   logic       rsp_last;
   logic       rsp_status;
   logic       rsp_equal_flag;

   alu_item_type pending_q[$];
   result_type   expected_q[$];
   logic [Dc-1:0][7:0] lhs_store;
   logic [Dc-1:0][7:0] rhs_store;
   int accepted_count = 0;
   int total_items = 0;
   int errors = 0;

   rotated_wide_int_alu_top dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Turns a stored operand into its value: un-reverse, gather the rotation
   // count and rotate right by it modulo the word width.
   function automatic rwia_pkg::word_type decode_operand(input logic [Dc-1:0][7:0] st);
      rwia_pkg::word_type raw;
      logic [Dc-1:0] rot_bits;
      int rot;
      raw = '0;
      for (int i = 0; i < Dc; i++) begin
         raw[i*Db +: Db] = st[Dc-1-i][6:0];
         rot_bits[i] = st[Dc-1-i][7];
      end
      rot = int'(64'(rot_bits) % Tb);
      if (rot == 0) return raw;
      return (raw >> rot) | (raw << (Tb - rot));
   endfunction

   task automatic predict_results(input alu_item_type it);
      rwia_pkg::word_type a, b, res;
      result_type r;
      if (it.cmd == rwia_pkg::CMD_LOAD) begin
         if (it.slot < Dc) begin
            lhs_store[it.slot] = it.lhs;
            rhs_store[it.slot] = it.rhs;
         end
         return;
      end
      if (it.cmd == CMD_SPARE_LO || it.cmd == CMD_SPARE_HI) return;
      a = decode_operand(lhs_store);
      b = decode_operand(rhs_store);
      r = '0;
      r.last = 1'b1;
      if (it.cmd == rwia_pkg::CMD_EQ) begin
         r.equal_flag = (a == b);
         expected_q = {expected_q, r};
         return;
      end
      if (it.cmd == rwia_pkg::CMD_DIV && b == '0) begin
         r.status = 1'b1;
         expected_q = {expected_q, r};
         return;
      end
      case (it.cmd)
         rwia_pkg::CMD_ADD: res = a + b;
         rwia_pkg::CMD_SUB: res = a - b;
         rwia_pkg::CMD_MUL: res = a * b;
         default: res = a / b;
      endcase
      for (int k = 0; k < Dc; k++) begin
         r.result_byte = res[(Dc-1-k)*Db +: Db];
         r.out_slot = 6'(k);
         r.last = (k == Dc - 1);
         expected_q = {expected_q, r};
      end
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic push_op(input logic [2:0] cmd);
      alu_item_type it;
      it = '0;
      it.cmd = cmd;
      it.slot = 6'($urandom);
      it.lhs = 8'($urandom);
      it.rhs = 8'($urandom);
      pending_q = {pending_q, it};
   endtask

   task automatic push_load(input int slot, input logic [7:0] lhs, input logic [7:0] rhs);
      alu_item_type it;
      it.cmd = rwia_pkg::CMD_LOAD;
      it.slot = 6'(slot);
      it.lhs = lhs;
      it.rhs = rhs;
      pending_q = {pending_q, it};
   endtask

   // Reloads both operands in full with a content pattern picked by style.
   task automatic push_operands(input int style);
      logic [7:0] l, r;
      for (int s = 0; s < Dc; s++) begin
         l = 8'($urandom);
         r = 8'($urandom);
         case (style)
            0: ;
            1: begin // small divisor before rotation: only the low logical digits carry value
               if (s < Dc - 2) r[6:0] = '0;
               if ($urandom_range(1, 0)) r[7] = 1'b0;
            end
            2: r = '0;
            3: r = l;
            4: begin
               l = 8'hff;
               r = $urandom_range(1, 0) ? 8'h7f : 8'h80;
            end
            default: begin // values without rotation
               l[7] = 1'b0;
               r[7] = 1'b0;
            end
         endcase
         push_load(s, l, r);
      end
   endtask

   initial begin
      int n;
      // Directed: all-zero operands, then all-ones bytes, then ignored items and a subtract.
      for (int s = 0; s < Dc; s++) push_load(s, 8'h00, 8'h00);
      push_op(rwia_pkg::CMD_DIV);
      push_op(rwia_pkg::CMD_EQ);
      push_op(rwia_pkg::CMD_ADD);
      for (int s = 0; s < Dc; s++) push_load(s, 8'hff, 8'hff);
      push_op(rwia_pkg::CMD_ADD);
      push_op(rwia_pkg::CMD_SUB);
      push_op(rwia_pkg::CMD_MUL);
      push_op(rwia_pkg::CMD_DIV);
      push_op(rwia_pkg::CMD_EQ);
      push_load(Dc, 8'h00, 8'h00);
      push_load(63, 8'h00, 8'h00);
      push_op(CMD_SPARE_LO);
      push_op(CMD_SPARE_HI);
      push_op(rwia_pkg::CMD_SUB);
      n = 0;
      while (n < RandItems) begin
         if ($urandom_range(99, 0) < 30) begin
            push_operands($urandom_range(5, 0));
            n += Dc;
            repeat ($urandom_range(3, 1)) begin
               push_op(3'($urandom_range(5, 1)));
               n++;
            end
         end else if ($urandom_range(99, 0) < 60) begin
            push_load($urandom_range(63, 0), 8'($urandom), 8'($urandom));
            n++;
         end else if ($urandom_range(99, 0) < 90) begin
            push_op(3'($urandom_range(5, 1)));
            n++;
         end else begin
            push_op($urandom_range(1, 0) ? CMD_SPARE_LO : CMD_SPARE_HI);
            n++;
         end
      end
      total_items = pending_q.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && accepted_count == total_items);
      wait (expected_q.size() == 0);
      repeat (600) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("** rotated_wide_int_alu_top: PASSED **");
      else
         $display("** rotated_wide_int_alu_top: FAILED **");
      $finish;
   end

   initial begin
      #6000000;
      $display("** rotated_wide_int_alu_top: FAILED **");
      $finish;
   end

   function automatic int send_idle_pct();
      if (accepted_count < total_items / 3) return 35;
      if (accepted_count < 2 * total_items / 3) return 63;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (accepted_count < total_items / 3) return 63;
      if (accepted_count < 2 * total_items / 3) return 35;
      return 0;
   endfunction

   // Driver: a new item goes out only when the previous one transferred or
   // nothing was on the port; result stalls are drawn at random.
   always @(posedge clock) begin
      alu_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct());
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_cmd <= it.cmd;
               req_byte_slot <= it.slot;
               req_lhs_byte <= it.lhs;
               req_rhs_byte <= it.rhs;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each request transfer, checks each result transfer.
   always @(posedge clock) begin
      alu_item_type it;
      result_type want;
      if (!reset && req_valid && !req_stall) begin
         it.cmd = req_cmd;
         it.slot = req_byte_slot;
         it.lhs = req_lhs_byte;
         it.rhs = req_rhs_byte;
         predict_results(it);
         accepted_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_q.pop_front();
            if (rsp_result_byte !== want.result_byte)
               report_mismatch($sformatf("result_byte %0h, want %0h",
                                         rsp_result_byte, want.result_byte));
            if (rsp_out_slot !== want.out_slot)
               report_mismatch($sformatf("out_slot %0d, want %0d",
                                         rsp_out_slot, want.out_slot));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %b, want %b", rsp_status, want.status));
            if (rsp_equal_flag !== want.equal_flag)
               report_mismatch($sformatf("equal_flag %b, want %b",
                                         rsp_equal_flag, want.equal_flag));
         end
      end
   end

endmodule

`default_nettype wire
